// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

// ----- rtl/rmgc_pkg.sv -----
// Shared constants and codes of the range minimum, GCD and count tree.
`timescale 1ns / 1ps
`default_nettype none
package rmgc_pkg;

    // Default sizing.
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_VALUE_WIDTH  = 32;
    localparam int DEF_ELEMENT_COUNT = 1024;

    // Fixed port widths.
    localparam int CFG_W   = 11;
    localparam int POS_W   = 10;
    localparam int START_W = 10;
    localparam int STOP_W  = 11;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 11;
    localparam int ACC_W   = CNT_W + 1;

    // Request type codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RANGE_ERR = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/range_min_gcd_count_tree.sv -----
// Top level: request sequencer over the segment tree memory and the GCD unit.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Segment tree holding minimum, GCD and minimum count per node in one RAM of
// 2*MAX_ELEMENTS entries. Requests are handled one at a time. A write stores
// the leaf and then, for each ancestor up to the root, does two RAM reads plus
// one binary GCD and a write back. A query visits up to 2*log2(element_count)
// nodes, each costing one RAM read and one GCD, followed, when the minimum is
// not zero, by one more GCD to test whether the minimum divides the GCD. The
// GCD unit and the single RAM read port set the rate. An empty or
// out-of-bounds range goes straight to the done state without tree access.
// A finished result waits in an output register while the next request is
// taken. The tree needs no clearing after reset: every position below
// element_count must be written before a query.
module range_min_gcd_count_tree #(
    parameter int MAX_ELEMENTS = rmgc_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_WIDTH  = rmgc_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rmgc_pkg::CFG_W-1:0]    cfg_data,
    // Request channel.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [rmgc_pkg::POS_W-1:0]    s_position,
    input  wire logic [rmgc_pkg::DATA_W-1:0]   s_value,
    input  wire logic [rmgc_pkg::START_W-1:0]  s_range_start,
    input  wire logic [rmgc_pkg::STOP_W-1:0]   s_range_stop,
    // Result channel.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_status,
    output logic      [rmgc_pkg::DATA_W-1:0]   m_range_min,
    output logic      [rmgc_pkg::DATA_W-1:0]   m_range_gcd,
    output logic      [rmgc_pkg::CNT_W-1:0]    m_min_count,
    output logic      [rmgc_pkg::CNT_W-1:0]    m_kept_count
);

    import rmgc_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int DEPTH = 2 * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = (NW > STOP_W ? NW : STOP_W) + 1;
    localparam int EW    = 2 * VW + CNT_W;
    localparam int RESET_COUNT =
        DEF_ELEMENT_COUNT > MAX_ELEMENTS ? MAX_ELEMENTS : DEF_ELEMENT_COUNT;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_W_PAR  = 11'b000_0000_0010,
        S_W_RDL  = 11'b000_0000_0100,
        S_W_RDR  = 11'b000_0000_1000,
        S_W_GCD  = 11'b000_0001_0000,
        S_Q_CHK  = 11'b000_0010_0000,
        S_Q_RD   = 11'b000_0100_0000,
        S_Q_GCD  = 11'b000_1000_0000,
        S_Q_DIV  = 11'b001_0000_0000,
        S_Q_DIVW = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [NW-1:0]     n_reg;
    logic [AW-1:0]     p_reg, p_next;
    logic [AW:0]       l_reg, l_next;
    logic [AW:0]       r_reg, r_next;
    logic [VW-1:0]     mn_reg, mn_next;
    logic [VW-1:0]     g_reg, g_next;
    logic [ACC_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic [STOP_W-1:0] total_reg, total_next;
    logic              div_reg, div_next;
    logic              err_reg, err_next;
    logic [EW-1:0]     left_reg, left_next;
    logic [VW-1:0]     node_min_reg, node_min_next;
    logic [CNT_W-1:0]  node_cnt_reg, node_cnt_next;

    logic              m_valid_reg, m_valid_next;
    logic              status_reg, status_next;
    logic [DATA_W-1:0] omin_reg, omin_next;
    logic [DATA_W-1:0] ogcd_reg, ogcd_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic [CNT_W-1:0]  okept_reg, okept_next;

    // RAM and GCD unit hookup.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;
    logic              gcd_start, gcd_done;
    logic [VW-1:0]     gcd_a, gcd_b, gcd_result;

    // Helper values.
    logic [CW-1:0]     n_ext, pos_ext, lo_ext, hi_ext, cfg_ext;
    logic [AW:0]       leaf_addr, r_dec;
    logic [VW-1:0]     rd_min, rd_gcd, lf_min, lf_gcd, pair_min;
    logic [CNT_W-1:0]  rd_cnt, lf_cnt, pair_cnt;
    logic [ACC_W-1:0]  total_ext, kept_val;

    rmgc_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_tree_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rmgc_gcd #(
        .WIDTH (VW)
    ) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .a       (gcd_a),
        .b       (gcd_b),
        .done    (gcd_done),
        .result  (gcd_result)
    );

    // Field views of the read and held entries.
    assign rd_min = ram_rdata[EW-1 -: VW];
    assign rd_gcd = ram_rdata[CNT_W +: VW];
    assign rd_cnt = ram_rdata[CNT_W-1:0];
    assign lf_min = left_reg[EW-1 -: VW];
    assign lf_gcd = left_reg[CNT_W +: VW];
    assign lf_cnt = left_reg[CNT_W-1:0];

    assign n_ext     = CW'(n_reg);
    assign pos_ext   = CW'(s_position);
    assign lo_ext    = CW'(s_range_start);
    assign hi_ext    = CW'(s_range_stop);
    assign cfg_ext   = CW'(cfg_data);
    assign leaf_addr = (AW + 1)'(n_reg) + (AW + 1)'(s_position);
    assign r_dec     = r_reg - (AW + 1)'(1);
    assign total_ext = ACC_W'(total_reg);

    // Parent combine of minimum and minimum count.
    always_comb begin
        pair_min = (rd_min < lf_min) ? rd_min : lf_min;
        pair_cnt = '0;
        if (lf_min == pair_min) begin
            pair_cnt = pair_cnt + lf_cnt;
        end
        if (rd_min == pair_min) begin
            pair_cnt = pair_cnt + rd_cnt;
        end
    end

    // Elements that do not divide the whole range.
    always_comb begin
        if (!div_reg) begin
            kept_val = total_ext;
        end else if (cnt_reg > total_ext) begin
            kept_val = '0;
        end else begin
            kept_val = total_ext - cnt_reg;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Request sequencer.
    always_comb begin
        state_next    = state_reg;
        p_next        = p_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        mn_next       = mn_reg;
        g_next        = g_reg;
        cnt_next      = cnt_reg;
        first_next    = first_reg;
        total_next    = total_reg;
        div_next      = div_reg;
        err_next      = err_reg;
        left_next     = left_reg;
        node_min_next = node_min_reg;
        node_cnt_next = node_cnt_reg;
        m_valid_next  = m_valid_reg;
        status_next   = status_reg;
        omin_next     = omin_reg;
        ogcd_next     = ogcd_reg;
        ocnt_next     = ocnt_reg;
        okept_next    = okept_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        gcd_start     = 1'b0;
        gcd_a         = '0;
        gcd_b         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_WRITE) begin
                        // Store the leaf, then climb if it has a parent.
                        if (pos_ext < n_ext) begin
                            ram_we    = 1'b1;
                            ram_waddr = leaf_addr[AW-1:0];
                            ram_wdata = {VW'(s_value), VW'(s_value), CNT_W'(1)};
                            p_next    = leaf_addr[AW:1];
                            if (leaf_addr[AW:1] != '0) begin
                                state_next = S_W_PAR;
                            end
                        end
                    end else if (lo_ext >= hi_ext || hi_ext > n_ext) begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        err_next   = 1'b0;
                        l_next     = (AW + 1)'(n_reg) + (AW + 1)'(s_range_start);
                        r_next     = (AW + 1)'(n_reg) + (AW + 1)'(s_range_stop);
                        first_next = 1'b1;
                        g_next     = '0;
                        mn_next    = '0;
                        cnt_next   = '0;
                        total_next = s_range_stop - STOP_W'(s_range_start);
                        state_next = S_Q_CHK;
                    end
                end
            end
            S_W_PAR: begin
                ram_re     = 1'b1;
                ram_raddr  = {p_reg[AW-2:0], 1'b0};
                state_next = S_W_RDL;
            end
            S_W_RDL: begin
                left_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = {p_reg[AW-2:0], 1'b1};
                state_next = S_W_RDR;
            end
            S_W_RDR: begin
                node_min_next = pair_min;
                node_cnt_next = pair_cnt;
                gcd_start     = 1'b1;
                gcd_a         = lf_gcd;
                gcd_b         = rd_gcd;
                state_next    = S_W_GCD;
            end
            S_W_GCD: begin
                if (gcd_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = p_reg;
                    ram_wdata = {node_min_reg, gcd_result, node_cnt_reg};
                    p_next    = p_reg >> 1;
                    if (p_reg[AW-1:1] == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_W_PAR;
                    end
                end
            end
            S_Q_CHK: begin
                // Walk the bounds up the tree, taking the odd border nodes.
                if (l_reg >= r_reg) begin
                    state_next = S_Q_DIV;
                end else if (l_reg[0]) begin
                    ram_re     = 1'b1;
                    ram_raddr  = l_reg[AW-1:0];
                    l_next     = l_reg + (AW + 1)'(1);
                    state_next = S_Q_RD;
                end else if (r_reg[0]) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_dec[AW-1:0];
                    r_next     = r_dec;
                    state_next = S_Q_RD;
                end else begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            S_Q_RD: begin
                if (first_reg || rd_min < mn_reg) begin
                    mn_next  = rd_min;
                    cnt_next = ACC_W'(rd_cnt);
                end else if (rd_min == mn_reg) begin
                    cnt_next = cnt_reg + ACC_W'(rd_cnt);
                end
                first_next = 1'b0;
                gcd_start  = 1'b1;
                gcd_a      = g_reg;
                gcd_b      = rd_gcd;
                state_next = S_Q_GCD;
            end
            S_Q_GCD: begin
                if (gcd_done) begin
                    g_next     = gcd_result;
                    state_next = S_Q_CHK;
                end
            end
            S_Q_DIV: begin
                // The minimum divides the GCD when gcd(g, min) equals min.
                if (mn_reg == '0) begin
                    div_next   = (g_reg == '0);
                    state_next = S_DONE;
                end else begin
                    gcd_start  = 1'b1;
                    gcd_a      = g_reg;
                    gcd_b      = mn_reg;
                    state_next = S_Q_DIVW;
                end
            end
            S_Q_DIVW: begin
                if (gcd_done) begin
                    div_next   = (gcd_result == mn_reg);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (err_reg) begin
                        status_next = STATUS_RANGE_ERR;
                        omin_next   = '0;
                        ogcd_next   = '0;
                        ocnt_next   = '0;
                        okept_next  = '0;
                    end else begin
                        status_next = STATUS_OK;
                        omin_next   = DATA_W'(mn_reg);
                        ogcd_next   = DATA_W'(g_reg);
                        ocnt_next   = cnt_reg[CNT_W-1:0];
                        okept_next  = kept_val[CNT_W-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Registers; configuration saturates into one to MAX_ELEMENTS.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            n_reg       <= NW'(RESET_COUNT);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_ext == '0) begin
                    n_reg <= NW'(1);
                end else if (cfg_ext > CW'(MAX_ELEMENTS)) begin
                    n_reg <= NW'(MAX_ELEMENTS);
                end else begin
                    n_reg <= cfg_ext[NW-1:0];
                end
            end
        end
        p_reg        <= p_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        mn_reg       <= mn_next;
        g_reg        <= g_next;
        cnt_reg      <= cnt_next;
        first_reg    <= first_next;
        total_reg    <= total_next;
        div_reg      <= div_next;
        err_reg      <= err_next;
        left_reg     <= left_next;
        node_min_reg <= node_min_next;
        node_cnt_reg <= node_cnt_next;
        status_reg   <= status_next;
        omin_reg     <= omin_next;
        ogcd_reg     <= ogcd_next;
        ocnt_reg     <= ocnt_next;
        okept_reg    <= okept_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_range_min  = omin_reg;
    assign m_range_gcd  = ogcd_reg;
    assign m_min_count  = ocnt_reg;
    assign m_kept_count = okept_reg;

    `ASSERT_CLK(a_parent_nonzero, aclk, aresetn, (state_reg == S_W_PAR) |-> (p_reg != '0))
    `ASSERT_CLK(a_write_states, aclk, aresetn,
                ram_we |-> (state_reg == S_IDLE || state_reg == S_W_GCD))
    `ASSERT_CLK(a_gcd_done_waiting, aclk, aresetn,
                gcd_done |-> (state_reg == S_W_GCD || state_reg == S_Q_GCD ||
                              state_reg == S_Q_DIVW))

endmodule
`default_nettype wire

// ----- rtl/rmgc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rmgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/rmgc_gcd.sv -----
// Iterative binary GCD unit, one subtract or shift step per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmgc_gcd #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    output logic                  done,
    output logic      [WIDTH-1:0] result
);

    localparam int KW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] result_reg, result_next;

    // One step of Stein's algorithm: strip common twos, then odd differences.
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        result_next = result_reg;
        if (start) begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            k_next    = '0;
        end else if (busy_reg) begin
            if (a_reg != '0 && b_reg != '0) begin
                if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_reg >= b_reg) begin
                    a_next = a_reg - b_reg;
                end else begin
                    b_next = b_reg - a_reg;
                end
            end else begin
                // One operand reached zero; the other, with the common twos, is the GCD.
                result_next = (a_reg | b_reg) << k_reg;
                done_next   = 1'b1;
                busy_next   = 1'b0;
            end
        end
    end

    // Control state is reset; operands and result are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_done_not_busy, aclk, aresetn, done_reg |-> !busy_reg)
    `ASSERT_CLK(a_finish_next, aclk, aresetn,
                (busy_reg && !start && (a_reg == '0 || b_reg == '0)) |=> done_reg)
    `ASSERT_NEVER(a_start_while_busy, aclk, aresetn, start && busy_reg)

endmodule
`default_nettype wire

// ----- test/range_min_gcd_count_tree_tb.sv -----
// Testbench for the range minimum, GCD and minimum count segment tree.
`timescale 1ns / 1ps
module range_min_gcd_count_tree_tb;
    import rmgc_pkg::*;

    localparam int TREE_SIZE = 2 * DEF_MAX_ELEMENTS;
    // Covers a full write walk of ten levels with the slowest GCD on each.
    localparam int DRAIN_CYCLES = 1500;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic               req_type;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  value;
        logic [START_W-1:0] range_start;
        logic [STOP_W-1:0]  range_stop;
    } request_t;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] range_min;
        logic [DATA_W-1:0] range_gcd;
        logic [CNT_W-1:0]  min_count;
        logic [CNT_W-1:0]  kept_count;
    } answer_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [CFG_W-1:0] cfg;
        request_t         req;
        bit               typed;
        answer_t          answer;
    } row_t;

    localparam answer_t RANGE_ERR_ANSWER = {STATUS_RANGE_ERR, 32'd0, 32'd0, 11'd0, 11'd0};

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_req_type = REQ_WRITE;
    logic [POS_W-1:0]    s_position = '0;
    logic [DATA_W-1:0]   s_value = '0;
    logic [START_W-1:0]  s_range_start = '0;
    logic [STOP_W-1:0]   s_range_stop = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_status;
    logic [DATA_W-1:0]   m_range_min;
    logic [DATA_W-1:0]   m_range_gcd;
    logic [CNT_W-1:0]    m_min_count;
    logic [CNT_W-1:0]    m_kept_count;

    // Predicted tree contents and the element count in force.
    logic [DATA_W-1:0]   tree_min [TREE_SIZE];
    logic [DATA_W-1:0]   tree_gcd [TREE_SIZE];
    logic [CNT_W-1:0]    tree_cnt [TREE_SIZE];
    int unsigned         leaf_base = DEF_ELEMENT_COUNT;
    longint unsigned     acc_min;
    longint unsigned     acc_gcd;
    int unsigned         acc_cnt;

    answer_t             answers_due[$];
    row_t                stimulus_table[$];
    int                  mismatches = 0;
    longint              cycles = 0;
    bit                  calm = 1'b0;
    bit                  hold_request = 1'b0;

    range_min_gcd_count_tree i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_position    (s_position),
        .s_value       (s_value),
        .s_range_start (s_range_start),
        .s_range_stop  (s_range_stop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_range_min   (m_range_min),
        .m_range_gcd   (m_range_gcd),
        .m_min_count   (m_min_count),
        .m_kept_count  (m_kept_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Cycle counter that ends a hung run.
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("range_min_gcd_count_tree_tb failed");
                $finish;
            end
        end
    end

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Recompute one inner node from its two children.
    function automatic void rebuild_node(int unsigned p);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] m;
        int unsigned c;
        ma = tree_min[2 * p];
        mb = tree_min[2 * p + 1];
        m = (ma < mb) ? ma : mb;
        c = 0;
        if (ma == m) c += tree_cnt[2 * p];
        if (mb == m) c += tree_cnt[2 * p + 1];
        tree_min[p] = m;
        tree_cnt[p] = c[CNT_W-1:0];
        tree_gcd[p] = gcd_of(tree_gcd[2 * p], tree_gcd[2 * p + 1]);
    endfunction

    // Merge one node into the running minimum, count and GCD of a query.
    function automatic void fold_node(int unsigned node);
        if (tree_min[node] < acc_min) begin
            acc_min = tree_min[node];
            acc_cnt = tree_cnt[node];
        end else if (tree_min[node] == acc_min) begin
            acc_cnt += tree_cnt[node];
        end
        acc_gcd = gcd_of(acc_gcd, tree_gcd[node]);
    endfunction

    // Apply one request to the predicted tree; returns 1 when it yields an answer.
    function automatic bit predict_request(input request_t r, output answer_t a);
        int unsigned p;
        int unsigned l;
        int unsigned h;
        int unsigned total;
        int unsigned kept;
        bit divides;
        a = '0;
        if (r.req_type == REQ_WRITE) begin
            if (r.position >= leaf_base) return 1'b0;
            p = leaf_base + r.position;
            tree_min[p] = r.value;
            tree_gcd[p] = r.value;
            tree_cnt[p] = 1;
            p = p >> 1;
            while (p >= 1) begin
                rebuild_node(p);
                p = p >> 1;
            end
            return 1'b0;
        end
        if (r.range_start >= r.range_stop || r.range_stop > leaf_base) begin
            a = RANGE_ERR_ANSWER;
            return 1'b1;
        end
        acc_min = '1;
        acc_cnt = 0;
        acc_gcd = 0;
        total = r.range_stop - r.range_start;
        l = leaf_base + r.range_start;
        h = leaf_base + r.range_stop;
        while (l < h) begin
            if ((l & 1) != 0) begin
                fold_node(l);
                l++;
            end
            if ((h & 1) != 0) begin
                h--;
                fold_node(h);
            end
            l = l >> 1;
            h = h >> 1;
        end
        divides = (acc_min == 0) ? (acc_gcd == 0) : (acc_gcd % acc_min == 0);
        kept = !divides ? total : (acc_cnt > total ? 0 : total - acc_cnt);
        a.status = STATUS_OK;
        a.range_min = acc_min[DATA_W-1:0];
        a.range_gcd = acc_gcd[DATA_W-1:0];
        a.min_count = acc_cnt[CNT_W-1:0];
        a.kept_count = kept[CNT_W-1:0];
        return 1'b1;
    endfunction

    // Values biased toward shared factors so that minima divide the GCD often.
    function automatic logic [DATA_W-1:0] pick_value(bit quick);
        int kind;
        logic [DATA_W-1:0] v;
        kind = quick ? $urandom_range(1) : $urandom_range(3);
        case (kind)
            0: v = $urandom_range(12, 1);
            1: v = $urandom_range(6, 1) << $urandom_range(quick ? 6 : 25);
            2: begin
                v = $urandom;
                if (v == 0) v = 1;
            end
            default: begin
                case ($urandom_range(2))
                    0: v = 32'hFFFF_FFFF;
                    1: v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFFE;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic row_t mk_row(row_kind_t kind, logic [CFG_W-1:0] cfg, logic req_type,
                                    logic [POS_W-1:0] pos, logic [DATA_W-1:0] val,
                                    logic [START_W-1:0] lo, logic [STOP_W-1:0] hi,
                                    bit typed, answer_t answer);
        row_t row;
        row.kind = kind;
        row.cfg = cfg;
        row.req = {req_type, pos, val, lo, hi};
        row.typed = typed;
        row.answer = answer;
        return row;
    endfunction

    // Offer one request and record its answer once the transfer happens.
    task automatic offer(request_t r, bit typed, answer_t typed_answer);
        answer_t a;
        s_valid <= 1'b1;
        s_req_type <= r.req_type;
        s_position <= r.position;
        s_value <= r.value;
        s_range_start <= r.range_start;
        s_range_stop <= r.range_stop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_request(r, a)) answers_due.push_back(typed ? typed_answer : a);
        if (!calm && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every answer is back and the last write is done.
    task automatic drain();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_element_count(logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (v < 1) leaf_base = 1;
        else if (v > DEF_MAX_ELEMENTS) leaf_base = DEF_MAX_ELEMENTS;
        else leaf_base = v;
    endtask

    // New element count, a full fill of the array, then random traffic.
    task automatic run_phase(logic [CFG_W-1:0] cfg, int count, bit quick, bit hold);
        request_t r;
        int unsigned n;
        int sel;
        write_element_count(cfg);
        n = leaf_base;
        for (int i = 0; i < n; i++) begin
            r = {REQ_WRITE, POS_W'(i), pick_value(quick), START_W'($urandom),
                 STOP_W'($urandom)};
            offer(r, 1'b0, '0);
        end
        if (hold) hold_request = 1'b1;
        repeat (count) begin
            sel = $urandom_range(99);
            r = {REQ_QUERY, POS_W'($urandom), pick_value(quick), START_W'($urandom),
                 STOP_W'($urandom)};
            if (sel < 65) begin
                r.range_start = $urandom_range(n - 1);
                r.range_stop = $urandom_range(n, r.range_start + 1);
            end else if (sel >= 75) begin
                r.req_type = REQ_WRITE;
                if (sel < 95 || n == DEF_MAX_ELEMENTS) r.position = $urandom_range(n - 1);
                else r.position = $urandom_range(DEF_MAX_ELEMENTS - 1, n);
            end
            offer(r, 1'b0, '0);
        end
    endtask

    // Result side: compare each transfer with the oldest expectation.
    initial begin
        answer_t want;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result, status %0d min %h", $realtime,
                             m_status, m_range_min);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $realtime,
                                 want.status, m_status);
                        mismatches++;
                    end
                    if (m_range_min !== want.range_min) begin
                        $display("%0t: range_min expected %h got %h", $realtime,
                                 want.range_min, m_range_min);
                        mismatches++;
                    end
                    if (m_range_gcd !== want.range_gcd) begin
                        $display("%0t: range_gcd expected %h got %h", $realtime,
                                 want.range_gcd, m_range_gcd);
                        mismatches++;
                    end
                    if (m_min_count !== want.min_count) begin
                        $display("%0t: min_count expected %0d got %0d", $realtime,
                                 want.min_count, m_min_count);
                        mismatches++;
                    end
                    if (m_kept_count !== want.kept_count) begin
                        $display("%0t: kept_count expected %0d got %0d", $realtime,
                                 want.kept_count, m_kept_count);
                        mismatches++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    // Request side: directed table, then random phases.
    initial begin
        // Range errors at the reset element count need no filled tree.
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 0, 1, RANGE_ERR_ANSWER));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 5, 3, 1, RANGE_ERR_ANSWER));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 1025, 1,
                                        RANGE_ERR_ANSWER));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 1023, 2047, 1,
                                        RANGE_ERR_ANSWER));
        // An element count above the maximum saturates, so a stop past it stays out of range.
        stimulus_table.push_back(mk_row(ROW_CFG, 2047, REQ_WRITE, 0, 1, 0, 0, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 1025, 1,
                                        RANGE_ERR_ANSWER));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 1023, 32'hFFFF_FFFF, 0, 1, 0, '0));
        // Single element: largest value, write past the end ignored, smallest value.
        stimulus_table.push_back(mk_row(ROW_CFG, 1, REQ_WRITE, 0, 1, 0, 0, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 0, 32'hFFFF_FFFF, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 1, 1,
                                        {STATUS_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1, 11'd0}));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 1, 7, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 2, 1, RANGE_ERR_ANSWER));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 0, 1, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 1, 1,
                                        {STATUS_OK, 32'd1, 32'd1, 11'd1, 11'd0}));
        // Two elements: minimum not dividing the GCD, then a tied minimum.
        stimulus_table.push_back(mk_row(ROW_CFG, 2, REQ_WRITE, 0, 1, 0, 0, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 0, 6, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 1, 4, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 2, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 1, 6, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 2, 1,
                                        {STATUS_OK, 32'd6, 32'd6, 11'd2, 11'd0}));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 1, 2, 0, '0));
        // Three elements, an odd tree shape.
        stimulus_table.push_back(mk_row(ROW_CFG, 3, REQ_WRITE, 0, 1, 0, 0, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 0, 12, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 1, 18, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_WRITE, 2, 12, 0, 1, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 3, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 2, 3, 0, '0));
        stimulus_table.push_back(mk_row(ROW_REQ, 0, REQ_QUERY, 0, 1, 0, 4, 1, RANGE_ERR_ANSWER));

        for (int i = 0; i < TREE_SIZE; i++) begin
            tree_min[i] = '0;
            tree_gcd[i] = '0;
            tree_cnt[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stimulus_table[i]) begin
            if (stimulus_table[i].kind == ROW_CFG) write_element_count(stimulus_table[i].cfg);
            else offer(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].answer);
        end

        run_phase(5, 100, 1'b0, 1'b0);
        run_phase(13, 100, 1'b0, 1'b1);
        run_phase(0, 60, 1'b0, 1'b0);
        calm = 1'b1;
        run_phase(64, 150, 1'b0, 1'b0);
        calm = 1'b0;
        run_phase(100, 150, 1'b0, 1'b0);
        run_phase(7, 80, 1'b0, 1'b0);
        run_phase(31, 80, 1'b0, 1'b0);

        drain();
        if (mismatches == 0) begin
            $display("range_min_gcd_count_tree_tb passed");
        end else begin
            $display("range_min_gcd_count_tree_tb failed");
        end
        $finish;
    end

endmodule

// ----- range_min_gcd_count_tree.f -----
+incdir+rtl
rtl/rmgc_pkg.sv
rtl/rmgc_ram.sv
rtl/rmgc_gcd.sv
rtl/range_min_gcd_count_tree.sv
test/range_min_gcd_count_tree_tb.sv
